[rtl/assert_macros.svh]
// Assertion helpers, clocked on clk and disabled while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a condition at every rising clock edge.
`define ASSERT_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Check a consequence in the same cycle as its cause.
`define ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check a consequence in the cycle after its cause.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/ardse_pkg.sv]
`timescale 1ns / 1ps
package ardse_pkg;

    localparam int DIM        = 4;
    localparam int COORD_W    = 16;
    localparam int SCALE_W    = 16;
    localparam int AMP_W      = 16;
    localparam int CFG_W      = 16;
    localparam int CFG_IDX_W  = (DIM + 1 > 1) ? $clog2(DIM + 1) : 1;
    localparam int DIST_W     = 16;
    localparam int PROD_W     = DIST_W + SCALE_W;
    localparam int P_W        = 23;
    localparam int SQ_W       = 2 * P_W;
    localparam int SUM_W      = SQ_W + $clog2(DIM);
    localparam int H_SHIFT    = 25;
    localparam int H_W        = SUM_W - H_SHIFT;
    localparam int FRAC_W     = 17;
    localparam int DIFF_W     = 16;
    localparam int R_W        = 12;
    localparam int IPROD_W    = DIFF_W + R_W;
    localparam int INT_W      = 25;
    localparam int M_W        = INT_W + FRAC_W;
    localparam int E_W        = 25;
    localparam int Q_W        = AMP_W + E_W;
    localparam int KV_W       = 16;
    localparam int PIPE_DEPTH = 7;

    localparam logic [PROD_W-1:0] P_CAP   = PROD_W'(6 << 20);
    localparam logic [H_W-1:0]    H_LIMIT = H_W'(16 << 16);

    localparam logic [CFG_IDX_W-1:0] REG_AMPLITUDE      = CFG_IDX_W'(0);
    localparam int                   REG_INV_SCALE_BASE = 1;

    localparam logic [AMP_W-1:0]   AMP_RESET   = AMP_W'(256);
    localparam logic [SCALE_W-1:0] SCALE_RESET = SCALE_W'(4096);

    // exp(-k/16) in Q1.16
    function automatic logic [FRAC_W-1:0] frac_lookup(input logic [4:0] idx);
        logic [FRAC_W-1:0] v;
        unique case (idx)
            5'd0:    v = 17'd65536;
            5'd1:    v = 17'd61565;
            5'd2:    v = 17'd57835;
            5'd3:    v = 17'd54331;
            5'd4:    v = 17'd51039;
            5'd5:    v = 17'd47947;
            5'd6:    v = 17'd45042;
            5'd7:    v = 17'd42313;
            5'd8:    v = 17'd39750;
            5'd9:    v = 17'd37341;
            5'd10:   v = 17'd35079;
            5'd11:   v = 17'd32954;
            5'd12:   v = 17'd30957;
            5'd13:   v = 17'd29081;
            5'd14:   v = 17'd27319;
            5'd15:   v = 17'd25664;
            5'd16:   v = 17'd24109;
            default: v = '0;
        endcase
        return v;
    endfunction

    // exp(-n) in Q1.24
    function automatic logic [INT_W-1:0] int_lookup(input logic [4:0] idx);
        logic [INT_W-1:0] v;
        unique case (idx)
            5'd0:    v = 25'd16777216;
            5'd1:    v = 25'd6171993;
            5'd2:    v = 25'd2270549;
            5'd3:    v = 25'd835288;
            5'd4:    v = 25'd307285;
            5'd5:    v = 25'd113044;
            5'd6:    v = 25'd41587;
            5'd7:    v = 25'd15299;
            5'd8:    v = 25'd5628;
            5'd9:    v = 25'd2070;
            5'd10:   v = 25'd762;
            5'd11:   v = 25'd280;
            5'd12:   v = 25'd103;
            5'd13:   v = 25'd38;
            5'd14:   v = 25'd14;
            5'd15:   v = 25'd5;
            5'd16:   v = 25'd2;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

[rtl/ardse_if.sv]
`timescale 1ns / 1ps
interface ardse_pair_if;
    import ardse_pkg::*;
    logic                                valid;
    logic                                ready;
    logic signed [DIM-1:0][COORD_W-1:0]  x;
    logic signed [DIM-1:0][COORD_W-1:0]  y;

    modport source (output valid, output x, output y, input ready);
    modport sink   (input valid, input x, input y, output ready);
endinterface

interface ardse_result_if;
    import ardse_pkg::*;
    logic              valid;
    logic              ready;
    logic [KV_W-1:0]   kernel_value;

    modport source (output valid, output kernel_value, input ready);
    modport sink   (input valid, input kernel_value, output ready);
endinterface

[rtl/ard_squared_exponential_kernel_core.sv]
`timescale 1ns / 1ps
// ARD squared-exponential kernel: kernel_value = amplitude * exp(-h) with
// h = 0.5 * sum ((x_i - y_i) * inv_scale_i)^2 over four dimensions, in
// fixed point (coordinates signed Q8.8, inverse scales unsigned Q4.12,
// amplitude and result unsigned Q8.8); a half-sum above 16 gives zero.
// Throughput is one vector pair per clock unless a held result word stalls;
// each pair passes from acceptance to a valid result word through the chain
// of registered stages (difference, scale, square, sum, interpolation,
// exponent, amplitude) and the output register. The whole pipeline advances
// whenever the output register is empty or being drained, so pair.ready is
// high while it is empty and follows result.ready while it holds a word.
// Registers: index 0 amplitude (reset 1.0), index 1..4 inv_scale_0..3
// (reset 1.0); writes to other indices are dropped. Write them only while
// no word is in flight.
module ard_squared_exponential_kernel_core (
    input  logic                            clk,
    input  logic                            rst_n,
    ardse_pair_if.sink                      pair,
    ardse_result_if.source                  result,
    input  logic                            cfg_we,
    input  logic [ardse_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [ardse_pkg::CFG_W-1:0]     cfg_data
);
    import ardse_pkg::*;

    logic                             en;
    logic [AMP_W-1:0]                 amplitude_reg;
    logic [DIM-1:0][SCALE_W-1:0]      inv_scale_reg;
    logic [DIM-1:0][SQ_W-1:0]         sq;
    logic [H_W-1:0]                   h;
    logic [KV_W-1:0]                  kv;
    logic [PIPE_DEPTH-1:0]            vld_reg, vld_next;
    logic                             out_valid_reg;
    logic [KV_W-1:0]                  out_data_reg;

    // advance everything when the output register can take a word
    assign en         = !out_valid_reg || result.ready;
    assign pair.ready = en;
    assign vld_next   = {vld_reg[PIPE_DEPTH-2:0], pair.valid};

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            amplitude_reg <= AMP_RESET;
            for (int i = 0; i < DIM; i++)
            begin
                inv_scale_reg[i] <= SCALE_RESET;
            end
        end
        else if (cfg_we)
        begin
            if (cfg_index == REG_AMPLITUDE)
            begin
                amplitude_reg <= cfg_data[AMP_W-1:0];
            end
            for (int i = 0; i < DIM; i++)
            begin
                if (cfg_index == CFG_IDX_W'(REG_INV_SCALE_BASE + i))
                begin
                    inv_scale_reg[i] <= cfg_data[SCALE_W-1:0];
                end
            end
        end
    end

    // one lane per dimension: difference, scale, square
    for (genvar g = 0; g < DIM; g++)
    begin : g_lane
        ardse_lane u_lane (
            .clk       (clk),
            .en        (en),
            .x         (pair.x[g]),
            .y         (pair.y[g]),
            .inv_scale (inv_scale_reg[g]),
            .sq        (sq[g])
        );
    end

    // combine the lanes into the half-sum
    ardse_merge u_merge (
        .clk (clk),
        .en  (en),
        .sq  (sq),
        .h   (h)
    );

    // table exponential and amplitude scaling
    ardse_exp u_exp (
        .clk          (clk),
        .en           (en),
        .h            (h),
        .amplitude    (amplitude_reg),
        .kernel_value (kv)
    );

    // valid tracking through the pipe, then the output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_reg       <= vld_next;
            out_valid_reg <= vld_reg[PIPE_DEPTH-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_data_reg <= kv;
        end
    end

    assign result.valid        = out_valid_reg;
    assign result.kernel_value = out_data_reg;
endmodule

[rtl/ardse_lane.sv]
`timescale 1ns / 1ps
module ardse_lane (
    input  logic                          clk,
    input  logic                          en,
    input  logic [ardse_pkg::COORD_W-1:0] x,
    input  logic [ardse_pkg::COORD_W-1:0] y,
    input  logic [ardse_pkg::SCALE_W-1:0] inv_scale,
    output logic [ardse_pkg::SQ_W-1:0]    sq
);
    import ardse_pkg::*;

    logic signed [COORD_W:0] diff;
    logic [COORD_W:0]        mag;
    logic [DIST_W-1:0]       a_reg, a_next;
    logic [PROD_W-1:0]       prod;
    logic [P_W-1:0]          p_reg, p_next;
    logic [SQ_W-1:0]         sq_reg, sq_next;

    always_comb
    begin
        diff    = $signed({x[COORD_W-1], x}) - $signed({y[COORD_W-1], y});
        mag     = diff[COORD_W] ? (COORD_W + 1)'(0) - diff : diff;
        a_next  = mag[DIST_W-1:0];
        prod    = PROD_W'(a_reg) * PROD_W'(inv_scale);
        // clamp at 6.0: beyond it the half-sum is already past the cutoff
        p_next  = (prod > P_CAP) ? P_CAP[P_W-1:0] : prod[P_W-1:0];
        sq_next = SQ_W'(p_reg) * SQ_W'(p_reg);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_reg  <= a_next;
            p_reg  <= p_next;
            sq_reg <= sq_next;
        end
    end

    assign sq = sq_reg;
endmodule

[rtl/ardse_merge.sv]
`timescale 1ns / 1ps
module ardse_merge (
    input  logic                                          clk,
    input  logic                                          en,
    input  logic [ardse_pkg::DIM-1:0][ardse_pkg::SQ_W-1:0] sq,
    output logic [ardse_pkg::H_W-1:0]                     h
);
    import ardse_pkg::*;

    logic [SUM_W-1:0] sum;
    logic [H_W-1:0]   h_reg, h_next;

    always_comb
    begin
        sum = '0;
        for (int i = 0; i < DIM; i++)
        begin
            sum = sum + SUM_W'(sq[i]);
        end
        h_next = sum[SUM_W-1:H_SHIFT];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            h_reg <= h_next;
        end
    end

    assign h = h_reg;
endmodule

[rtl/ardse_exp.sv]
`timescale 1ns / 1ps
module ardse_exp (
    input  logic                          clk,
    input  logic                          en,
    input  logic [ardse_pkg::H_W-1:0]     h,
    input  logic [ardse_pkg::AMP_W-1:0]   amplitude,
    output logic [ardse_pkg::KV_W-1:0]    kernel_value
);
    import ardse_pkg::*;

    logic [3:0]          k;
    logic [R_W-1:0]      r;
    logic [FRAC_W-1:0]   hi, lo;
    logic [FRAC_W-1:0]   span;
    logic [FRAC_W-1:0]   f;
    logic [IPROD_W:0]    iprod_rnd;
    logic [M_W:0]        m_rnd;
    logic [Q_W:0]        q_rnd;

    logic                zero5_reg, zero5_next, zero6_reg, zero7_reg;
    logic [4:0]          n_reg, n_next;
    logic [FRAC_W-1:0]   hi_reg;
    logic [IPROD_W-1:0]  iprod_reg, iprod_next;
    logic [M_W-1:0]      m_reg, m_next;
    logic [Q_W-1:0]      q_reg, q_next;

    always_comb
    begin
        // split the half-sum: integer part, sixteenths, remainder
        zero5_next = (h > H_LIMIT);
        n_next     = h[20:16];
        k          = h[15:12];
        r          = h[R_W-1:0];
        hi         = frac_lookup({1'b0, k});
        lo         = frac_lookup({1'b0, k} + 5'd1);
        span       = hi - lo;
        iprod_next = IPROD_W'(span[DIFF_W-1:0]) * IPROD_W'(r);

        iprod_rnd  = {1'b0, iprod_reg} + (IPROD_W + 1)'(2048);
        f          = hi_reg - FRAC_W'(iprod_rnd >> 12);
        m_next     = M_W'(int_lookup(n_reg)) * M_W'(f);

        m_rnd      = {1'b0, m_reg} + (M_W + 1)'(32768);
        q_next     = Q_W'(amplitude) * Q_W'(m_rnd[16 +: E_W]);

        q_rnd      = {1'b0, q_reg} + (Q_W + 1)'(1 << 23);
        kernel_value = zero7_reg ? '0 : q_rnd[24 +: KV_W];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            zero5_reg <= zero5_next;
            n_reg     <= n_next;
            hi_reg    <= hi;
            iprod_reg <= iprod_next;
            zero6_reg <= zero5_reg;
            m_reg     <= m_next;
            zero7_reg <= zero6_reg;
            q_reg     <= q_next;
        end
    end
endmodule

[rtl/ardse_checker.sv]
`timescale 1ns / 1ps
`include "assert_macros.svh"
module ardse_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            in_valid,
    input logic                            in_ready,
    input logic                            out_valid,
    input logic                            out_ready,
    input logic [ardse_pkg::KV_W-1:0]      kernel_value,
    input logic                            cfg_we,
    input logic [ardse_pkg::CFG_IDX_W-1:0] cfg_index,
    input logic [ardse_pkg::CFG_W-1:0]     cfg_data
);
    import ardse_pkg::*;

    logic [AMP_W-1:0] amp_reg;

    // shadow the amplitude register from the write port
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            amp_reg <= AMP_RESET;
        end
        else if (cfg_we && cfg_index == REG_AMPLITUDE)
        begin
            amp_reg <= cfg_data[AMP_W-1:0];
        end
    end

    `ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(kernel_value), "result word dropped or changed while stalled")
    `ASSERT_IMPLY(a_ready_when_empty, !out_valid, in_ready, "input stalled with empty output register")
    `ASSERT_IMPLY(a_ready_follows_out, out_valid, in_ready == out_ready, "input ready does not follow output drain")
    `ASSERT_IMPLY(a_stall_needs_full, in_valid && !in_ready, out_valid && !out_ready, "input word held off while output can move")
    `ASSERT_IMPLY(a_below_amp, out_valid, kernel_value <= amp_reg, "kernel value above amplitude")
endmodule

bind ard_squared_exponential_kernel_core ardse_checker u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (pair.valid),
    .in_ready     (pair.ready),
    .out_valid    (result.valid),
    .out_ready    (result.ready),
    .kernel_value (result.kernel_value),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
);
